// ===== rtl/tjs_pkg.sv =====
// ----------------------------------------------------------------------------
// tjs_pkg: shared types and arithmetic for the two-joint skinning block
// Palette geometry, queue word layout, sequencer states and Q16.16 helpers.
// ----------------------------------------------------------------------------
package tjs_pkg;

  localparam int NUM_JOINTS = 32;
  localparam int JOINT_W    = $clog2(NUM_JOINTS);
  localparam int ROWS       = 4;
  localparam int COLS       = 3;
  localparam int ADDR_W     = JOINT_W + 2;
  localparam int PAL_DEPTH  = NUM_JOINTS * ROWS;
  localparam int ROW_W      = 32 * COLS;
  localparam int Q_DEPTH    = 2;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 52;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PIVOT  = 2'd1,
    FUNC_VERTEX = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RA, ST_RB, ST_BM, ST_BA, ST_TM, ST_TA, ST_DONE
  } state_t;

  typedef struct packed {
    func_t                 op;
    logic [JOINT_W-1:0]    ja;
    logic [JOINT_W-1:0]    jb;
    logic [1:0]            row;
    logic [15:0]           frac;
    logic [COLS-1:0][31:0] v;
    logic [COLS-1:0][31:0] n;
  } q_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // round half up of a Q32.32 product back to Q16.16
  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return ACC_W'(t >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -(ACC_W'(64'sd2147483648))) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/two_joint_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// two_joint_vertex_skinning: two-joint linear blend skinning in Q16.16
// Usage:
//   Input words arrive on in_valid/in_stall. func selects a palette row load,
//   a pivot fold into row 3 of a joint, or a vertex skin. Only vertex words
//   produce a result word on out_valid/out_stall (positions and normals).
//   A two-entry queue decouples the input side from the sequencer, so words
//   keep being accepted, until the queue fills, while the sequencer works or a result waits.
//   The sequencer works on one word at a time and takes a load straight
//   from idle; a vertex may also wait on out_stall. Its pace is set by the
//   single read port of the palette RAM (two row reads per blended row) and
//   by one shared multiplier per column that runs the blend and the
//   three-term dot products one term at a time. Unused func codes and loads
//   or pivots to a joint past the palette are accepted and dropped.
//   Reset clears the queue, the sequencer and out_valid; palette contents
//   are not cleared and must be loaded before use. A stalled result holds
//   its fields until taken; the sequencer then waits in its final step.
// ----------------------------------------------------------------------------
module two_joint_vertex_skinning import tjs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [4:0]  joint_index,
  input  logic [1:0]  row_index,
  input  logic [31:0] value_a,
  input  logic [31:0] value_b,
  input  logic [31:0] value_c,
  input  logic [20:0] blend_weight,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [31:0] norm_x,
  output logic [31:0] norm_y,
  output logic [31:0] norm_z
);

  logic             q_valid;
  q_word_t          q_word;
  logic             q_pop;
  ram_req_t         ram_req;
  logic [ROW_W-1:0] ram_rdata;

  tjs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .joint_index, .row_index,
    .value_a, .value_b, .value_c, .blend_weight, .normal_x, .normal_y,
    .normal_z, .q_valid, .q_word, .q_pop
  );

  tjs_ram #(.WIDTH(ROW_W), .DEPTH(PAL_DEPTH)) u_palette (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  tjs_back u_back (
    .clk, .rst, .q_valid, .q_word, .q_pop, .ram_req, .ram_rdata,
    .out_valid, .out_stall, .pos_x, .pos_y, .pos_z, .norm_x, .norm_y, .norm_z
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled with an empty queue");

  a_reset_out: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid right after reset");

  a_write_idle_pop: assert property (@(posedge clk) disable iff (rst)
    (q_pop && ram_req.we) |-> (q_word.op == FUNC_LOAD))
    else $error("palette written by a non-load word at pop");

endmodule

// ===== rtl/tjs_ram.sv =====
// ----------------------------------------------------------------------------
// tjs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tjs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tjs_front.sv =====
// ----------------------------------------------------------------------------
// tjs_front: input classification and command queue
// Accepts words, drops the ones with no effect, resolves joints and queues
// the rest for the back end.
// ----------------------------------------------------------------------------
module tjs_front import tjs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [4:0]  joint_index,
  input  logic [1:0]  row_index,
  input  logic [31:0] value_a,
  input  logic [31:0] value_b,
  input  logic [31:0] value_c,
  input  logic [20:0] blend_weight,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  output logic        q_valid,
  output q_word_t     q_word,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_word_t            mem [Q_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  q_word_t            word_in;
  logic               keep;
  logic               push;
  logic [JOINT_W-1:0] k0;
  logic [JOINT_W-1:0] k1;

  always_comb begin
    // clamp both blend joints to the last palette entry
    k0 = (int'(blend_weight[20:16]) > NUM_JOINTS - 1) ? JOINT_W'(NUM_JOINTS - 1)
                                                        : JOINT_W'(blend_weight[20:16]);
    k1 = (int'(blend_weight[20:16]) + 1 > NUM_JOINTS - 1) ? JOINT_W'(NUM_JOINTS - 1)
                                                            : JOINT_W'(int'(blend_weight[20:16]) + 1);
    word_in.op   = func_t'(func);
    word_in.row  = row_index;
    word_in.v    = {value_c, value_b, value_a};
    word_in.n    = {normal_z, normal_y, normal_x};
    word_in.ja   = JOINT_W'(joint_index);
    word_in.jb   = JOINT_W'(joint_index);
    word_in.frac = '0;
    keep         = 1'b0;
    unique case (func_t'(func))
      FUNC_LOAD, FUNC_PIVOT: begin
        keep = int'(joint_index) < NUM_JOINTS;
      end
      FUNC_VERTEX: begin
        keep         = 1'b1;
        word_in.ja   = k0;
        word_in.jb   = k1;
        word_in.frac = blend_weight[15:0];
      end
      FUNC_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign q_word   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (int'(wptr) == Q_DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= (int'(rptr) == Q_DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(q_pop);
    end
    if (push) begin
      mem[wptr] <= word_in;
    end
  end

endmodule

// ===== rtl/tjs_back.sv =====
// ----------------------------------------------------------------------------
// tjs_back: palette sequencer and transform datapath
// Runs loads, pivot folds and vertex skinning with one multiplier per column.
// ----------------------------------------------------------------------------
module tjs_back import tjs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  q_word_t          q_word,
  output logic             q_pop,
  output ram_req_t         ram_req,
  input  logic [ROW_W-1:0] ram_rdata,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      pos_x,
  output logic [31:0]      pos_y,
  output logic [31:0]      pos_z,
  output logic [31:0]      norm_x,
  output logic [31:0]      norm_y,
  output logic [31:0]      norm_z
);

  state_t    state;
  state_t    state_next;
  q_word_t   cur;
  logic [1:0] row;
  logic [1:0] step;
  logic       nrm;
  logic       out_load;

  logic signed [31:0]       a_reg  [COLS];
  logic signed [31:0]       bm     [ROWS][COLS];
  logic signed [PROD_W-1:0] prod   [COLS];
  logic signed [ACC_W-1:0]  acc    [COLS];
  logic signed [31:0]       res_p  [COLS];
  logic signed [31:0]       res_n  [COLS];
  logic signed [MUL_W-1:0]  ma     [COLS];
  logic signed [MUL_W-1:0]  mb     [COLS];
  logic signed [ACC_W-1:0]  acc_next [COLS];
  logic signed [ACC_W-1:0]  blend  [COLS];
  logic signed [31:0]       vec;

  assign vec = nrm ? $signed(cur.n[step]) : $signed(cur.v[step]);

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      if (state == ST_BM) begin
        ma[c] = MUL_W'($signed(ram_rdata[32*c +: 32])) - MUL_W'(a_reg[c]);
        mb[c] = $signed({17'b0, cur.frac});
      end else begin
        ma[c] = MUL_W'(vec);
        mb[c] = MUL_W'(bm[step][c]);
      end
      blend[c]    = ACC_W'(a_reg[c]) + rnd16(prod[c]);
      acc_next[c] = ((step == 2'd0) ? (nrm ? '0 : ACC_W'(bm[3][c])) : acc[c])
                    + rnd16(prod[c]);
    end
  end

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    ram_req       = '0;
    ram_req.raddr = {cur.ja, row};
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_word.op == FUNC_LOAD) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = {q_word.ja, q_word.row};
            ram_req.wdata = q_word.v;
          end else begin
            state_next = ST_RA;
          end
        end
      end
      ST_RA: state_next = ST_RB;
      ST_RB: begin
        ram_req.raddr = {cur.jb, row};
        state_next    = ST_BM;
      end
      ST_BM: state_next = ST_BA;
      ST_BA: state_next = (row == 2'd3) ? ST_TM : ST_RA;
      ST_TM: state_next = ST_TA;
      ST_TA: begin
        if (step == 2'd2 && (nrm || cur.op == FUNC_PIVOT)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_TM;
        end
      end
      ST_DONE: begin
        if (cur.op == FUNC_PIVOT) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = {cur.ja, 2'd3};
          ram_req.wdata = {res_p[2], res_p[1], res_p[0]};
          state_next    = ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row       <= '0;
      step      <= '0;
      nrm       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        row <= '0;
      end else if (state == ST_BA) begin
        row <= row + 1'b1;
      end
      if (state == ST_BA || (state == ST_TA && step == 2'd2)) begin
        step <= '0;
      end else if (state == ST_TA) begin
        step <= step + 1'b1;
      end
      if (state == ST_BA) begin
        nrm <= 1'b0;
      end else if (state == ST_TA && step == 2'd2) begin
        nrm <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_word;
    end
    for (int c = 0; c < COLS; c++) begin
      if (state == ST_RB) begin
        a_reg[c] <= $signed(ram_rdata[32*c +: 32]);
      end
      if (state == ST_BM || state == ST_TM) begin
        prod[c] <= ma[c] * mb[c];
      end
      if (state == ST_BA) begin
        bm[row][c] <= sat32(blend[c]);
      end
      if (state == ST_TA) begin
        acc[c] <= acc_next[c];
        if (step == 2'd2 && !nrm) begin
          res_p[c] <= sat32(acc_next[c]);
        end
        // hold the normal until the result word can be loaded
        if (step == 2'd2 && nrm) begin
          res_n[c] <= sat32(acc_next[c]);
        end
      end
    end
    if (out_load) begin
      pos_x  <= res_p[0];
      pos_y  <= res_p[1];
      pos_z  <= res_p[2];
      norm_x <= res_n[0];
      norm_y <= res_n[1];
      norm_z <= res_n[2];
    end
  end

endmodule

// ===== tb/tb_two_joint_vertex_skinning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_joint_vertex_skinning: self-checking bench for the skinning block
// Loads joint rows, folds pivots and skins vertices through random gaps on
// both handshakes; every result word is checked against a palette model.
// ----------------------------------------------------------------------------
module tb_two_joint_vertex_skinning;
  import tjs_pkg::*;

  typedef struct {
    func_t       fn;
    logic [4:0]  joint;
    logic [1:0]  row;
    int          va, vb, vc;
    logic [20:0] weight;
    int          nx, ny, nz;
  } skin_word_t;

  typedef struct {
    logic [31:0] px, py, pz, nx, ny, nz;
  } skin_out_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  func = 0;
  logic [4:0]  joint_index = 0;
  logic [1:0]  row_index = 0;
  logic [31:0] value_a = 0, value_b = 0, value_c = 0;
  logic [20:0] blend_weight = 0;
  logic [31:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;

  two_joint_vertex_skinning DUT (.*);

  always #2 clk = ~clk;

  skin_word_t word_q[$];
  skin_out_t  skinned_q[$];
  int         pal[32][4][3];
  bit         row_loaded[32][4];
  int         errors = 0;
  int         n_vertex = 0, n_pivot = 0, n_load = 0, n_results = 0;

  function automatic longint rq16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic bit joint_ready(int j);
    return row_loaded[j][0] && row_loaded[j][1] && row_loaded[j][2] && row_loaded[j][3];
  endfunction

  // update palette model and queue the expected result
  task automatic push_word(skin_word_t w);
    int        k0, k1, c, r;
    longint    a, b, s, n;
    int        bm[4][3];
    skin_out_t o;
    word_q.push_back(w);
    case (w.fn)
      FUNC_LOAD: begin
        pal[w.joint][w.row][0] = w.va;
        pal[w.joint][w.row][1] = w.vb;
        pal[w.joint][w.row][2] = w.vc;
        row_loaded[w.joint][w.row] = 1;
        n_load++;
      end
      FUNC_PIVOT: begin
        for (c = 0; c < 3; c++) begin
          s = longint'(pal[w.joint][3][c]) + rq16(longint'(w.va) * pal[w.joint][0][c])
            + rq16(longint'(w.vb) * pal[w.joint][1][c])
            + rq16(longint'(w.vc) * pal[w.joint][2][c]);
          pal[w.joint][3][c] = int'(clip32(s));
        end
        n_pivot++;
      end
      FUNC_VERTEX: begin
        k0 = w.weight[20:16];
        k1 = (k0 >= 31) ? 31 : k0 + 1;
        for (r = 0; r < 4; r++)
          for (c = 0; c < 3; c++) begin
            a = pal[k0][r][c];
            b = pal[k1][r][c];
            bm[r][c] = int'(clip32(a + rq16((b - a) * longint'(w.weight[15:0]))));
          end
        for (c = 0; c < 3; c++) begin
          s = longint'(bm[3][c]) + rq16(longint'(w.va) * bm[0][c])
            + rq16(longint'(w.vb) * bm[1][c]) + rq16(longint'(w.vc) * bm[2][c]);
          n = rq16(longint'(w.nx) * bm[0][c]) + rq16(longint'(w.ny) * bm[1][c])
            + rq16(longint'(w.nz) * bm[2][c]);
          if (c == 0) begin o.px = clip32(s); o.nx = clip32(n); end
          if (c == 1) begin o.py = clip32(s); o.ny = clip32(n); end
          if (c == 2) begin o.pz = clip32(s); o.nz = clip32(n); end
        end
        skinned_q.push_back(o);
        n_vertex++;
      end
      default: ;
    endcase
  endtask

  function automatic int rand_q;
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return int'($urandom);
      default: return int'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    endcase
  endfunction

  function automatic skin_word_t mk_word(func_t fn, int j, int r, int a, int b, int c,
                                         logic [20:0] wt, int x, int y, int z);
    skin_word_t w;
    w.fn = fn; w.joint = 5'(j); w.row = 2'(r); w.va = a; w.vb = b; w.vc = c;
    w.weight = wt; w.nx = x; w.ny = y; w.nz = z;
    return w;
  endfunction

  function automatic skin_word_t rand_word(func_t fn);
    return mk_word(fn, $urandom_range(0, 31), $urandom_range(0, 3), rand_q(), rand_q(),
                   rand_q(), 21'($urandom), rand_q(), rand_q(), rand_q());
  endfunction

  // stimulus
  initial begin
    skin_word_t w;
    int         i, r, k, sel;
    for (r = 0; r < 4; r++) begin
      push_word(mk_word(FUNC_LOAD, 0, r, (r == 0) ? 32'h10000 : 0,
                        (r == 1) ? 32'h10000 : 0, (r == 2) ? 32'h10000 : 0, 0, 0, 0, 0));
      push_word(mk_word(FUNC_LOAD, 1, r, 32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, 0));
      push_word(mk_word(FUNC_LOAD, 31, r, rand_q(), rand_q(), rand_q(), 0, 0, 0, 0));
    end
    push_word(mk_word(FUNC_NONE, 0, 3, -1, -1, -1, 21'h1fffff, -1, -1, -1));
    push_word(mk_word(FUNC_VERTEX, 0, 0, 32'h30000, -32'h20000, 32'h8000, 0,
                      32'h10000, 0, 0));
    push_word(mk_word(FUNC_VERTEX, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                      21'h0ffff, 32'sh80000000, 32'sh7fffffff, -1));
    push_word(mk_word(FUNC_VERTEX, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      21'h08000, 32'sh7fffffff, 32'sh80000000, 0));
    push_word(mk_word(FUNC_PIVOT, 0, 0, 32'h10000, -32'h10000, 32'h18000, 0, 0, 0, 0));
    push_word(mk_word(FUNC_PIVOT, 1, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                      0, 0, 0, 0));
    push_word(mk_word(FUNC_VERTEX, 0, 0, rand_q(), rand_q(), rand_q(), 21'h1fffff,
                      rand_q(), rand_q(), rand_q()));
    push_word(mk_word(FUNC_VERTEX, 0, 0, rand_q(), rand_q(), rand_q(), 21'h1f0000,
                      rand_q(), rand_q(), rand_q()));

    for (i = 0; i < 1950; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        push_word(rand_word(FUNC_LOAD));
      end else if (sel < 29) begin
        w = rand_word(FUNC_PIVOT);
        while (!joint_ready(w.joint)) w.joint = 5'($urandom_range(0, 31));
        push_word(w);
      end else if (sel < 32) begin
        push_word(rand_word(FUNC_NONE));
      end else begin
        w = rand_word(FUNC_VERTEX);
        k = w.weight[20:16];
        while (!joint_ready(k) || !joint_ready((k >= 31) ? 31 : k + 1))
          k = $urandom_range(0, 31);
        w.weight[20:16] = 5'(k);
        case ($urandom_range(0, 7))
          0: w.weight[15:0] = 16'h0000;
          1: w.weight[15:0] = 16'hffff;
          default: ;
        endcase
        push_word(w);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
  end

  // input driver: change at falling edge, acceptance seen at rising edge
  bit in_taken = 0;
  int in_gap = 0;
  int out_wait = 0;
  bit burst = 0;

  always @(posedge clk)
    in_taken <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (!rst && (in_taken || !in_valid)) begin
      if (in_gap > 0) begin
        in_valid <= 0;
        in_gap   <= in_gap - 1;
      end else if (word_q.size() > 0) begin
        skin_word_t w;
        w = word_q.pop_front();
        in_valid     <= 1;
        func         <= w.fn;
        joint_index  <= w.joint;
        row_index    <= w.row;
        value_a      <= w.va;
        value_b      <= w.vb;
        value_c      <= w.vc;
        blend_weight <= w.weight;
        normal_x     <= w.nx;
        normal_y     <= w.ny;
        normal_z     <= w.nz;
        if ($urandom_range(0, 63) == 0) burst = ~burst;
        in_gap <= burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_stall <= 1;
      out_wait  <= out_wait - 1;
    end else begin
      out_stall <= 0;
    end
  end

  // result monitor and watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("%0t: timeout with %0d words queued and %0d results pending",
                 $time, word_q.size(), skinned_q.size());
        $display("tb_two_joint_vertex_skinning: done, errors");
        $finish;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      skin_out_t e;
      n_results++;
      out_wait <= burst ? 0 : $urandom_range(0, 7);
      if (skinned_q.size() == 0) begin
        $display("%0t: unexpected result word pos %h %h %h", $time, pos_x, pos_y, pos_z);
        errors++;
      end else begin
        e = skinned_q.pop_front();
        if ({pos_x, pos_y, pos_z, norm_x, norm_y, norm_z} !==
            {e.px, e.py, e.pz, e.nx, e.ny, e.nz}) begin
          $display("%0t: result mismatch expected pos %h %h %h norm %h %h %h", $time,
                   e.px, e.py, e.pz, e.nx, e.ny, e.nz);
          $display("%0t:                  actual pos %h %h %h norm %h %h %h", $time,
                   pos_x, pos_y, pos_z, norm_x, norm_y, norm_z);
          errors++;
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    wait (word_q.size() == 0 && skinned_q.size() == 0 && !in_valid);
    repeat (100) @(posedge clk);
    $display("Sent %0d loads, %0d pivots, %0d vertices; checked %0d result words.",
             n_load, n_pivot, n_vertex, n_results);
    if (errors == 0) $display("tb_two_joint_vertex_skinning: done, clean");
    else $display("tb_two_joint_vertex_skinning: done, errors");
    $finish;
  end

endmodule
